[hdl/lmq_pkg.sv]
// ----------------------------------------------------------------------------
// lmq_pkg
// Shared types and constants for the Lamport mutex queue node.
// ----------------------------------------------------------------------------
package lmq_pkg;

  localparam int unsigned Resources = 8;
  localparam int unsigned Nodes     = 16;
  localparam int unsigned ResW      = 3;
  localparam int unsigned NodeW     = 4;
  localparam int unsigned TsW       = 32;
  localparam int unsigned FillW     = $clog2(Nodes + 1);
  localparam int unsigned SlotW     = $clog2(Nodes);

  localparam logic [2:0] CmdRemReq = 3'd0;
  localparam logic [2:0] CmdRemRel = 3'd1;
  localparam logic [2:0] CmdLocReq = 3'd2;
  localparam logic [2:0] CmdLocRel = 3'd3;
  localparam logic [2:0] CmdQuery  = 3'd4;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindReply = 2'd1;
  localparam logic [1:0] KindBReq  = 2'd2;
  localparam logic [1:0] KindBRel  = 2'd3;

  localparam logic [1:0] ErrOk      = 2'd0;
  localparam logic [1:0] ErrFull    = 2'd1;
  localparam logic [1:0] ErrMissing = 2'd2;

  localparam logic CfgNodeId   = 1'b0;
  localparam logic CfgInitClk  = 1'b1;

  typedef struct packed {
    logic [TsW-1:0]   ts;
    logic [NodeW-1:0] node;
  } entry_t;

  // Operation broadcast along the row of cells.
  typedef struct packed {
    logic             ins;   // shift in entry at insert point
    logic             rem;   // remove matched entry, shift down
    entry_t           ent;
  } cell_op_t;

endpackage

[hdl/lamport_mutex_queue_node.sv]
// ----------------------------------------------------------------------------
// lamport_mutex_queue_node
// An accepted item is registered first; the result register then loads while the
// cell row compares and shifts. The input stalls while the row updates and while a
// stalled result is held, so no new item is taken until the last one is through.
// Reset: asynchronous, clears all queues and loads the clock with zero.
// ----------------------------------------------------------------------------
module lamport_mutex_queue_node (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [2:0]  resource_i,
  input  logic [3:0]  sender_i,
  input  logic [31:0] msg_timestamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_timestamp_o,
  output logic [2:0]  out_resource_o,
  output logic [3:0]  out_target_o,
  output logic        granted_o,
  output logic [1:0]  error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned R = lmq_pkg::Resources;

  logic [3:0]  node_id_q;
  logic [31:0] clk_q, clk_d;
  logic        busy_q;
  logic [2:0]  cmd_q;
  logic [2:0]  res_q;
  logic [3:0]  snd_q;
  logic [31:0] ts_q;
  logic        ovld_q;
  logic [1:0]  kind_q;
  logic [31:0] ots_q;
  logic [2:0]  ores_q;
  logic [3:0]  otgt_q;
  logic        grant_q;
  logic [1:0]  err_q;

  logic        in_acc, cfg_acc, valid_op;
  logic [31:0] mx, inc;
  lmq_pkg::cell_op_t op;
  logic [R-1:0] full, dup, found, hvld;
  lmq_pkg::entry_t head [R];
  logic [1:0]  kind_d, err_d;
  logic        grant_d;

  assign in_stall_o  = busy_q || (ovld_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign valid_op = cmd_q <= lmq_pkg::CmdQuery;
  assign mx  = (cmd_q == lmq_pkg::CmdRemReq || cmd_q == lmq_pkg::CmdRemRel) &&
               ts_q > clk_q ? ts_q : clk_q;
  assign inc = (mx == 32'hFFFF_FFFF) ? mx : mx + 32'd1;

  always_comb begin
    op.ins      = busy_q && valid_op &&
                  (cmd_q == lmq_pkg::CmdRemReq || cmd_q == lmq_pkg::CmdLocReq);
    op.rem      = busy_q && valid_op &&
                  (cmd_q == lmq_pkg::CmdRemRel || cmd_q == lmq_pkg::CmdLocRel);
    op.ent.ts   = (cmd_q == lmq_pkg::CmdRemReq) ? ts_q : inc;
    op.ent.node = (cmd_q[1]) ? node_id_q : snd_q;
  end

  for (genvar r = 0; r < R; r++) begin : g_row
    lmq_row u_row (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .sel_i      (res_q == 3'(r)),
      .op_i       (op),
      .full_o     (full[r]),
      .dup_o      (dup[r]),
      .found_o    (found[r]),
      .head_o     (head[r]),
      .head_vld_o (hvld[r])
    );
  end

  always_comb begin
    kind_d  = lmq_pkg::KindNone;
    err_d   = lmq_pkg::ErrOk;
    grant_d = 1'b0;
    clk_d   = clk_q;
    if (valid_op) begin
      unique case (cmd_q)
        lmq_pkg::CmdRemReq: begin
          clk_d  = inc;
          kind_d = lmq_pkg::KindReply;
          if (full[res_q] && !dup[res_q]) err_d = lmq_pkg::ErrFull;
        end
        lmq_pkg::CmdRemRel: begin
          clk_d = inc;
          if (!found[res_q]) err_d = lmq_pkg::ErrMissing;
        end
        lmq_pkg::CmdLocReq: begin
          clk_d  = inc;
          kind_d = lmq_pkg::KindBReq;
          if (full[res_q] && !dup[res_q]) err_d = lmq_pkg::ErrFull;
        end
        lmq_pkg::CmdLocRel: begin
          clk_d  = inc;
          kind_d = lmq_pkg::KindBRel;
          if (!found[res_q]) err_d = lmq_pkg::ErrMissing;
        end
        default: begin
          grant_d = hvld[res_q] && head[res_q].node == node_id_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      ovld_q    <= 1'b0;
      node_id_q <= 4'd0;
      clk_q     <= 32'd0;
    end else begin
      if (out_valid_o && !out_stall_i) ovld_q <= 1'b0;
      if (in_acc) busy_q <= 1'b1;
      if (busy_q) begin
        busy_q <= 1'b0;
        ovld_q <= 1'b1;
        clk_q  <= clk_d;
      end
      if (cfg_acc) begin
        if (cfg_index_i == lmq_pkg::CfgNodeId) node_id_q <= cfg_data_i;
        else clk_q <= {28'd0, cfg_data_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      res_q <= resource_i;
      snd_q <= sender_i;
      ts_q  <= msg_timestamp_i;
    end
    if (busy_q) begin
      kind_q  <= kind_d;
      ots_q   <= (kind_d == lmq_pkg::KindNone) ? 32'd0 : clk_d;
      ores_q  <= (kind_d == lmq_pkg::KindNone) ? 3'd0 : res_q;
      otgt_q  <= (kind_d == lmq_pkg::KindReply) ? snd_q : 4'd0;
      grant_q <= grant_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o     = ovld_q;
  assign out_kind_o      = kind_q;
  assign out_timestamp_o = ots_q;
  assign out_resource_o  = ores_q;
  assign out_target_o    = otgt_q;
  assign granted_o       = grant_q;
  assign error_o         = err_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_acc) else $error("item accepted while busy");
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q && ovld_q) else $error("result not produced");
  a_clk_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(busy_q) && !$past(cfg_acc) |-> clk_q >= $past(clk_q))
    else $error("clock went backward");
`endif

endmodule

[hdl/lmq_cell.sv]
// ----------------------------------------------------------------------------
// lmq_cell
// One queue slot of one resource: holds an entry and its valid bit, compares
// against the operand and shifts with its neighbors.
// ----------------------------------------------------------------------------
module lmq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  lmq_pkg::cell_op_t op_i,
  input  logic              shift_i,     // takes the operand or the neighbor's entry on insert
  input  logic              rm_prev_i,   // this or an earlier cell matched for removal
  input  lmq_pkg::entry_t   prev_ent_i,
  input  logic              prev_vld_i,
  input  lmq_pkg::entry_t   next_ent_i,
  input  logic              next_vld_i,
  output lmq_pkg::entry_t   ent_o,
  output logic              vld_o,
  output logic              before_o,   // stored entry orders strictly before operand
  output logic              dup_o,
  output logic              match_o
);

  lmq_pkg::entry_t ent_q, ent_d;
  logic            vld_q, vld_d;
  logic            at_pt;

  assign before_o = vld_q && ((ent_q.ts < op_i.ent.ts) ||
                    (ent_q.ts == op_i.ent.ts && ent_q.node < op_i.ent.node));
  assign dup_o    = vld_q && ent_q == op_i.ent;
  assign match_o  = vld_q && ent_q.node == op_i.ent.node;
  assign at_pt    = shift_i;

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    if (clr_i) begin
      vld_d = 1'b0;
    end else if (op_i.ins && at_pt) begin
      // insert point takes the operand; later cells take prev when it is occupied
      ent_d = prev_vld_i ? prev_ent_i : op_i.ent;
      vld_d = 1'b1;
    end else if (op_i.rem && rm_prev_i) begin
      ent_d = next_ent_i;
      vld_d = next_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign vld_o = vld_q;

endmodule

[hdl/lmq_row.sv]
// ----------------------------------------------------------------------------
// lmq_row
// The ordered queue of one resource as a row of cells. Insert and remove shift
// every cell past the operation point.
// ----------------------------------------------------------------------------
module lmq_row (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sel_i,
  input  lmq_pkg::cell_op_t op_i,
  output logic              full_o,
  output logic              dup_o,
  output logic              found_o,
  output lmq_pkg::entry_t   head_o,
  output logic              head_vld_o
);

  localparam int unsigned N = lmq_pkg::Nodes;

  lmq_pkg::entry_t ent [N];
  logic [N-1:0]    vld, lower, dup, match;
  logic [N-1:0]    shift, rmp;
  lmq_pkg::cell_op_t op;
  logic            do_ins;

  // Cells stay packed at the low end, so lower[] is a prefix of ones.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      shift[i] = !lower[i];
    end
    rmp[0] = match[0];
    for (int i = 1; i < N; i++) begin
      rmp[i] = rmp[i-1] | match[i];
    end
  end

  assign full_o  = vld[N-1];
  assign dup_o   = |dup;
  assign found_o = |match;
  assign do_ins  = op_i.ins && !dup_o && !full_o;

  always_comb begin
    op     = op_i;
    op.ins = sel_i && do_ins;
    op.rem = sel_i && op_i.rem;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    lmq_pkg::entry_t pe, ne;
    logic            pv, nv;
    logic            sh;
    if (i == 0) begin : g_first
      assign pe = op_i.ent;
      assign pv = 1'b0;
      assign sh = shift[0];
    end else begin : g_mid
      assign pe = ent[i-1];
      assign pv = shift[i-1] && vld[i-1];
      // an empty neighbor past the insert point leaves this cell alone
      assign sh = shift[i] && !(shift[i-1] && !vld[i-1]);
    end
    if (i == N - 1) begin : g_last
      assign ne = ent[i];
      assign nv = 1'b0;
    end else begin : g_inner
      assign ne = ent[i+1];
      assign nv = vld[i+1];
    end
    lmq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (1'b0),
      .op_i       (op),
      .shift_i    (sh),
      .rm_prev_i  (rmp[i]),
      .prev_ent_i (pe),
      .prev_vld_i (pv),
      .next_ent_i (ne),
      .next_vld_i (nv),
      .ent_o      (ent[i]),
      .vld_o      (vld[i]),
      .before_o   (lower[i]),
      .dup_o      (dup[i]),
      .match_o    (match[i])
    );
  end

  assign head_o     = ent[0];
  assign head_vld_o = vld[0];

endmodule
